[hw/rtl/upmix5_pkg.sv]
// upmix5_pkg: widths, types, coefficients and the multiply-accumulate program
// for the stereo to five-channel upmix unit
// no dependencies
package upmix5_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH   = 32;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + 4;
   localparam int FRAC_BITS    = 30;
   localparam int NUM_FILTERS  = 6;
   localparam int NUM_STEPS    = 36;
   localparam int STEP_WIDTH   = $clog2(NUM_STEPS);
   localparam int FILT_WIDTH   = $clog2(NUM_FILTERS);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic [STEP_WIDTH-1:0]          step_idx_type;
   typedef logic [FILT_WIDTH-1:0]          filt_type;

   localparam sample_type S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam acc_type    Q30_HALF = acc_type'(64'sd1 << (FRAC_BITS - 1));
   localparam longint     CLIP_THR_L =
      (99 * (longint'(1) << (SAMPLE_WIDTH - 1)) + 50) / 100;
   localparam logic signed [SAMPLE_WIDTH:0] CLIP_THR = (SAMPLE_WIDTH+1)'(CLIP_THR_L);

   localparam step_idx_type LAST_STEP = step_idx_type'(NUM_STEPS - 1);

   // output_mode register values
   localparam logic [1:0] MODE_MUTE_ALL  = 2'd0;
   localparam logic [1:0] MODE_NO_CENTER = 2'd1;
   localparam logic [1:0] MODE_ALL       = 2'd2;
   localparam logic [1:0] MODE_RESERVED  = 2'd3;

   localparam coef_type G_M1DB   = 32'sd956973474;
   localparam coef_type G_M4DB   = 32'sd677484920;
   localparam coef_type G_M10DB  = 32'sd339547230;
   localparam coef_type G_M3P9DB = 32'sd685329678;
   localparam coef_type G_M9P5DB = 32'sd359665930;

   localparam logic [1:0] KIND_LPF11K = 2'd0;
   localparam logic [1:0] KIND_HPF5K  = 2'd1;
   localparam logic [1:0] KIND_HPF3K  = 2'd2;

   // a0 a1 a2 -b1 -b2
   localparam coef_type BQ_COEF [3][5] = '{
      '{32'sd295478837, 32'sd590957674, 32'sd295478837, 32'sd177430198, -32'sd285603721},
      '{32'sd710028503, -32'sd1420057006, 32'sd710028503, 32'sd1256424982,
        -32'sd509947206},
      '{32'sd843995873, -32'sd1687991746, 32'sd843995873, 32'sd1621204445,
        -32'sd681037223}
   };

   typedef enum logic [3:0] {
      SRC_IN_L, SRC_IN_R, SRC_L, SRC_R, SRC_SL, SRC_SR, SRC_Y,
      SRC_X1, SRC_X2, SRC_Y1, SRC_Y2
   } src_type;

   typedef enum logic [3:0] {
      DST_L, DST_R, DST_SL, DST_SR, DST_Y, DST_C, DST_FL, DST_TR, DST_FR
   } dst_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_RUN, ST_DRAIN, ST_CLIP
   } state_type;

   typedef struct packed {
      src_type  src;
      src_type  xsrc;
      filt_type filt;
      coef_type coef;
      logic     first;
      logic     last;
      logic     hist;
      dst_type  dst;
   } step_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_type;

   function automatic step_type gain_step(src_type s, coef_type g, dst_type d);
      step_type r;
      r.src   = s;
      r.xsrc  = s;
      r.filt  = '0;
      r.coef  = g;
      r.first = 1'b1;
      r.last  = 1'b1;
      r.hist  = 1'b0;
      r.dst   = d;
      return r;
   endfunction

   function automatic step_type bq_step(logic [2:0] j, src_type x, filt_type f,
                                        logic [1:0] kind, dst_type d);
      step_type r;
      r.xsrc  = x;
      r.filt  = f;
      r.coef  = BQ_COEF[kind][j];
      r.first = (j == 3'd0);
      r.last  = (j == 3'd4);
      r.hist  = 1'b1;
      r.dst   = d;
      case (j)
         3'd0:    r.src = x;
         3'd1:    r.src = SRC_X1;
         3'd2:    r.src = SRC_X2;
         3'd3:    r.src = SRC_Y1;
         default: r.src = SRC_Y2;
      endcase
      return r;
   endfunction

   function automatic step_type get_step(step_idx_type i);
      step_type r;
      if (i == 6'd0)
         r = gain_step(SRC_IN_L, G_M1DB, DST_L);
      else if (i == 6'd1)
         r = gain_step(SRC_IN_R, G_M1DB, DST_R);
      else if (i < 6'd7)
         r = bq_step(3'(i - 6'd2), SRC_L, 3'd0, KIND_LPF11K, DST_SL);
      else if (i < 6'd12)
         r = bq_step(3'(i - 6'd7), SRC_L, 3'd1, KIND_HPF5K, DST_Y);
      else if (i == 6'd12)
         r = gain_step(SRC_Y, G_M10DB, DST_C);
      else if (i < 6'd18)
         r = bq_step(3'(i - 6'd13), SRC_SL, 3'd2, KIND_HPF3K, DST_Y);
      else if (i == 6'd18)
         r = gain_step(SRC_Y, G_M4DB, DST_FL);
      else if (i < 6'd24)
         r = bq_step(3'(i - 6'd19), SRC_R, 3'd3, KIND_LPF11K, DST_SR);
      else if (i < 6'd29)
         r = bq_step(3'(i - 6'd24), SRC_R, 3'd4, KIND_HPF5K, DST_Y);
      else if (i == 6'd29)
         r = gain_step(SRC_Y, G_M9P5DB, DST_TR);
      else if (i < 6'd35)
         r = bq_step(3'(i - 6'd30), SRC_SR, 3'd5, KIND_HPF3K, DST_Y);
      else
         r = gain_step(SRC_Y, G_M3P9DB, DST_FR);
      return r;
   endfunction

endpackage

[hw/rtl/stereo_to_five_channel_upmix_unit.sv]
// stereo_to_five_channel_upmix_unit: -1 dB input gain, six biquads and output gains
// on one shared multiply-accumulate unit, front clipping and output muting
// depends on upmix5_pkg
//
//   channel  ports                        direction  carries
//   req      req_valid/ready, left/right  in         one stereo word
//   rsp      rsp_valid/ready, 5 channels  out        one five-channel word
//   csr      csr_valid/ready, output_mode in         output mode register
//
// a word is accepted, then runs 36 multiply-accumulate steps on the
// single multiplier, with a drain state after each of the 12 filter or gain
// results, and a final step for front clipping
// reset clears the filter histories, the sequencer and sets output_mode to 2
// a result waiting on rsp does not block the next req word; the next result
// holds in the clip step until the output register frees up
module stereo_to_five_channel_upmix_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] req_left_in,
   input  logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] req_right_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] rsp_front_left,
   output logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] rsp_front_right,
   output logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] rsp_surround_left,
   output logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] rsp_surround_right,
   output logic signed [upmix5_pkg::SAMPLE_WIDTH-1:0] rsp_center,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_output_mode
);

   upmix5_pkg::state_type    state_ff, state_in;
   upmix5_pkg::step_idx_type step_ff, step_in;
   logic [1:0]               mode_ff;

   upmix5_pkg::sample_type in_l_ff, in_r_ff, l_ff, r_ff, sl_ff, sr_ff, y_ff;
   upmix5_pkg::sample_type c_ff, fl_ff, tr_ff, fr_ff;
   upmix5_pkg::hist_type   hist_ff [upmix5_pkg::NUM_FILTERS];

   upmix5_pkg::prod_type prod_ff, prod_in;
   upmix5_pkg::acc_type  acc_ff, acc_in;
   upmix5_pkg::step_type pstep_ff, cur;
   logic                 pv_ff;

   upmix5_pkg::sample_type out_fl_ff, out_fr_ff, out_sl_ff, out_sr_ff, out_c_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic issue, load_out, step_inc;
   upmix5_pkg::sample_type op_val, x_val, y_res;
   upmix5_pkg::acc_type    base, sum;
   logic signed [upmix5_pkg::ACC_WIDTH-upmix5_pkg::FRAC_BITS-1:0] shifted;
   logic signed [upmix5_pkg::SAMPLE_WIDTH:0] fl_sum, fr_sum;
   upmix5_pkg::sample_type fl_clip, fr_clip;

   function automatic upmix5_pkg::sample_type pick(
      upmix5_pkg::src_type s, upmix5_pkg::hist_type h,
      upmix5_pkg::sample_type il, upmix5_pkg::sample_type ir,
      upmix5_pkg::sample_type l, upmix5_pkg::sample_type r,
      upmix5_pkg::sample_type sl, upmix5_pkg::sample_type sr,
      upmix5_pkg::sample_type y);
      upmix5_pkg::sample_type v;
      case (s)
         upmix5_pkg::SRC_IN_L: v = il;
         upmix5_pkg::SRC_IN_R: v = ir;
         upmix5_pkg::SRC_L:    v = l;
         upmix5_pkg::SRC_R:    v = r;
         upmix5_pkg::SRC_SL:   v = sl;
         upmix5_pkg::SRC_SR:   v = sr;
         upmix5_pkg::SRC_Y:    v = y;
         upmix5_pkg::SRC_X1:   v = h.x1;
         upmix5_pkg::SRC_X2:   v = h.x2;
         upmix5_pkg::SRC_Y1:   v = h.y1;
         upmix5_pkg::SRC_Y2:   v = h.y2;
         default:              v = '0;
      endcase
      return v;
   endfunction

   function automatic upmix5_pkg::sample_type clip_front(
      logic signed [upmix5_pkg::SAMPLE_WIDTH:0] v);
      upmix5_pkg::sample_type r;
      if (v > upmix5_pkg::CLIP_THR)
         r = upmix5_pkg::S_MAX;
      else if (v < -upmix5_pkg::CLIP_THR)
         r = upmix5_pkg::S_MIN;
      else
         r = upmix5_pkg::SAMPLE_WIDTH'(v);
      return r;
   endfunction

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur      = upmix5_pkg::get_step(step_ff);
      case (state_ff)
         upmix5_pkg::ST_IDLE: begin
            if (req_valid)
               state_in = upmix5_pkg::ST_RUN;
         end
         upmix5_pkg::ST_RUN: begin
            if (cur.last)
               state_in = upmix5_pkg::ST_DRAIN;
         end
         upmix5_pkg::ST_DRAIN: begin
            if (step_ff == upmix5_pkg::LAST_STEP)
               state_in = upmix5_pkg::ST_CLIP;
            else
               state_in = upmix5_pkg::ST_RUN;
         end
         upmix5_pkg::ST_CLIP: begin
            if (!rsp_valid_ff || rsp_ready)
               state_in = upmix5_pkg::ST_IDLE;
         end
         default: state_in = upmix5_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_out  = 1'b0;
      step_inc  = 1'b0;
      case (state_ff)
         upmix5_pkg::ST_IDLE:  req_ready = 1'b1;
         upmix5_pkg::ST_RUN: begin
            issue    = 1'b1;
            step_inc = !cur.last;
         end
         upmix5_pkg::ST_DRAIN: step_inc = (step_ff != upmix5_pkg::LAST_STEP);
         upmix5_pkg::ST_CLIP:  load_out = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      if (req_valid && req_ready)
         step_in = '0;
      else if (step_inc)
         step_in = step_ff + 1'b1;
      else
         step_in = step_ff;
   end

   // shared multiply-accumulate
   always_comb begin
      op_val  = pick(cur.src, hist_ff[cur.filt], in_l_ff, in_r_ff, l_ff, r_ff,
                     sl_ff, sr_ff, y_ff);
      prod_in = upmix5_pkg::PROD_WIDTH'(op_val) * upmix5_pkg::PROD_WIDTH'(cur.coef);
      base    = pstep_ff.first ? upmix5_pkg::Q30_HALF : acc_ff;
      sum     = base + upmix5_pkg::ACC_WIDTH'(prod_ff);
      acc_in  = sum;
      shifted = sum[upmix5_pkg::ACC_WIDTH-1:upmix5_pkg::FRAC_BITS];
      if (shifted > upmix5_pkg::S_MAX)
         y_res = upmix5_pkg::S_MAX;
      else if (shifted < upmix5_pkg::S_MIN)
         y_res = upmix5_pkg::S_MIN;
      else
         y_res = upmix5_pkg::SAMPLE_WIDTH'(shifted);
      x_val = pick(pstep_ff.xsrc, hist_ff[pstep_ff.filt], in_l_ff, in_r_ff, l_ff, r_ff,
                   sl_ff, sr_ff, y_ff);
   end

   // front clipping; muting is applied when the output registers load
   always_comb begin
      fl_sum  = (upmix5_pkg::SAMPLE_WIDTH+1)'(fl_ff) + (upmix5_pkg::SAMPLE_WIDTH+1)'(c_ff);
      fr_sum  = (upmix5_pkg::SAMPLE_WIDTH+1)'(fr_ff) + (upmix5_pkg::SAMPLE_WIDTH+1)'(tr_ff);
      fl_clip = clip_front(fl_sum);
      fr_clip = clip_front(fr_sum);
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= upmix5_pkg::ST_IDLE;
         step_ff      <= '0;
         mode_ff      <= upmix5_pkg::MODE_ALL;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < upmix5_pkg::NUM_FILTERS; i++)
            hist_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pv_ff        <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid)
            mode_ff <= csr_output_mode;
         if (pv_ff && pstep_ff.last && pstep_ff.hist) begin
            hist_ff[pstep_ff.filt].x2 <= hist_ff[pstep_ff.filt].x1;
            hist_ff[pstep_ff.filt].x1 <= x_val;
            hist_ff[pstep_ff.filt].y2 <= hist_ff[pstep_ff.filt].y1;
            hist_ff[pstep_ff.filt].y1 <= y_res;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_l_ff <= req_left_in;
         in_r_ff <= req_right_in;
      end
      if (issue) begin
         prod_ff  <= prod_in;
         pstep_ff <= cur;
      end
      if (pv_ff) begin
         acc_ff <= acc_in;
         if (pstep_ff.last) begin
            case (pstep_ff.dst)
               upmix5_pkg::DST_L:  l_ff  <= y_res;
               upmix5_pkg::DST_R:  r_ff  <= y_res;
               upmix5_pkg::DST_SL: sl_ff <= y_res;
               upmix5_pkg::DST_SR: sr_ff <= y_res;
               upmix5_pkg::DST_Y:  y_ff  <= y_res;
               upmix5_pkg::DST_C:  c_ff  <= y_res;
               upmix5_pkg::DST_FL: fl_ff <= y_res;
               upmix5_pkg::DST_TR: tr_ff <= y_res;
               upmix5_pkg::DST_FR: fr_ff <= y_res;
               default: ;
            endcase
         end
      end
      if (load_out) begin
         out_fl_ff <= fl_clip;
         out_fr_ff <= fr_clip;
         out_sl_ff <= (mode_ff == upmix5_pkg::MODE_NO_CENTER ||
                       mode_ff == upmix5_pkg::MODE_ALL) ? sl_ff : '0;
         out_sr_ff <= (mode_ff == upmix5_pkg::MODE_NO_CENTER ||
                       mode_ff == upmix5_pkg::MODE_ALL) ? sr_ff : '0;
         out_c_ff  <= (mode_ff == upmix5_pkg::MODE_ALL) ? c_ff : '0;
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_front_left     = out_fl_ff;
   assign rsp_front_right    = out_fr_ff;
   assign rsp_surround_left  = out_sl_ff;
   assign rsp_surround_right = out_sr_ff;
   assign rsp_center         = out_c_ff;

`ifndef ASSERT_OFF
   a_drain_has_product: assert property (@(posedge clock) disable iff (reset)
      state_ff == upmix5_pkg::ST_DRAIN |-> pv_ff && pstep_ff.last)
      else $error("drain cycle without a finishing product");

   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == upmix5_pkg::ST_RUN && step_ff == '0)
      else $error("sequencer did not restart at step zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_left))
      else $error("pending result overwritten");
`endif

endmodule

[tb/sv/upmix5_checker.sv]
// upmix5_checker: watches the req, rsp and csr channels of the upmix unit,
// predicts each five-channel word and compares it against the rsp channel
// depends on upmix5_pkg
module upmix5_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  upmix5_pkg::sample_type req_left_in,
   input  upmix5_pkg::sample_type req_right_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  upmix5_pkg::sample_type rsp_front_left,
   input  upmix5_pkg::sample_type rsp_front_right,
   input  upmix5_pkg::sample_type rsp_surround_left,
   input  upmix5_pkg::sample_type rsp_surround_right,
   input  upmix5_pkg::sample_type rsp_center,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_output_mode,
   output int                     errors,
   output int                     pending
);

   localparam int LPF11 = 0;
   localparam int HPF5 = 1;
   localparam int HPF3 = 2;
   localparam longint ROUND_HALF = longint'(1) << 29;
   localparam longint SMP_MAX = (longint'(1) << (upmix5_pkg::SAMPLE_WIDTH - 1)) - 1;
   localparam longint SMP_MIN = -SMP_MAX - 1;
   localparam longint CLIP_LEVEL =
      (99 * (longint'(1) << (upmix5_pkg::SAMPLE_WIDTH - 1)) + 50) / 100;
   localparam longint GAIN_M1 = 956973474;
   localparam longint GAIN_M4 = 677484920;
   localparam longint GAIN_M10 = 339547230;
   localparam longint GAIN_M3P9 = 685329678;
   localparam longint GAIN_M9P5 = 359665930;

   // a0 a1 a2 b1 b2, feedback terms subtracted
   localparam longint FILT_COEF [3][5] = '{
      '{295478837, 590957674, 295478837, -177430198, 285603721},
      '{710028503, -1420057006, 710028503, -1256424982, 509947206},
      '{843995873, -1687991746, 843995873, -1621204445, 681037223}
   };

   typedef struct {
      upmix5_pkg::sample_type fl;
      upmix5_pkg::sample_type fr;
      upmix5_pkg::sample_type sl;
      upmix5_pkg::sample_type sr;
      upmix5_pkg::sample_type c;
   } upmix_word_type;

   upmix_word_type expected_words[$];
   longint         x_hist [12];
   longint         y_hist [12];
   logic [1:0]     mode;

   function automatic longint clamp(longint v);
      if (v > SMP_MAX) return SMP_MAX;
      if (v < SMP_MIN) return SMP_MIN;
      return v;
   endfunction

   function automatic longint scale(longint x, longint g);
      return clamp((x * g + ROUND_HALF) >>> 30);
   endfunction

   function automatic longint run_biquad(int f, longint x, int kind);
      longint acc, y;
      int k;
      k = 2 * f;
      acc = FILT_COEF[kind][0] * x + FILT_COEF[kind][1] * x_hist[k]
          + FILT_COEF[kind][2] * x_hist[k+1] - FILT_COEF[kind][3] * y_hist[k]
          - FILT_COEF[kind][4] * y_hist[k+1];
      y = clamp((acc + ROUND_HALF) >>> 30);
      y_hist[k+1] = y_hist[k];
      y_hist[k] = y;
      x_hist[k+1] = x_hist[k];
      x_hist[k] = x;
      return y;
   endfunction

   function automatic longint clip_front(longint v);
      if (v > CLIP_LEVEL) return SMP_MAX;
      if (v < -CLIP_LEVEL) return SMP_MIN;
      return v;
   endfunction

   function automatic upmix_word_type predict_upmix(longint lin, longint rin);
      upmix_word_type w;
      longint l, r, sl, sr, c, fl, tr, fr;
      l = scale(lin, GAIN_M1);
      r = scale(rin, GAIN_M1);
      sl = run_biquad(0, l, LPF11);
      c = scale(run_biquad(1, l, HPF5), GAIN_M10);
      fl = clip_front(scale(run_biquad(2, sl, HPF3), GAIN_M4) + c);
      sr = run_biquad(3, r, LPF11);
      tr = scale(run_biquad(4, r, HPF5), GAIN_M9P5);
      fr = clip_front(scale(run_biquad(5, sr, HPF3), GAIN_M3P9) + tr);
      if (mode != upmix5_pkg::MODE_ALL) begin
         c = 0;
         if (mode != upmix5_pkg::MODE_NO_CENTER) begin
            sl = 0;
            sr = 0;
         end
      end
      w.fl = upmix5_pkg::sample_type'(fl);
      w.fr = upmix5_pkg::sample_type'(fr);
      w.sl = upmix5_pkg::sample_type'(sl);
      w.sr = upmix5_pkg::sample_type'(sr);
      w.c = upmix5_pkg::sample_type'(c);
      return w;
   endfunction

   assign pending = expected_words.size();

   always @(posedge clock) begin
      upmix_word_type e;
      if (reset) begin
         for (int i = 0; i < 12; i++) begin
            x_hist[i] = 0;
            y_hist[i] = 0;
         end
         mode = upmix5_pkg::MODE_ALL;
         expected_words.delete();
         errors = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected rsp word fl=%0d fr=%0d", rsp_front_left,
                           rsp_front_right);
            end else begin
               e = expected_words.pop_front();
               if (e.fl !== rsp_front_left || e.fr !== rsp_front_right ||
                   e.sl !== rsp_surround_left || e.sr !== rsp_surround_right ||
                   e.c !== rsp_center) begin
                  errors++;
                  if (errors <= 10) begin
                     $write("rsp word mismatch exp fl=%0d fr=%0d sl=%0d sr=%0d c=%0d",
                            e.fl, e.fr, e.sl, e.sr, e.c);
                     $display(" got fl=%0d fr=%0d sl=%0d sr=%0d c=%0d",
                              rsp_front_left, rsp_front_right, rsp_surround_left,
                              rsp_surround_right, rsp_center);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(predict_upmix(longint'(req_left_in),
                                                   longint'(req_right_in)));
         if (csr_valid && csr_ready)
            mode = csr_output_mode;
      end
   end

endmodule

[tb/sv/tb_stereo_to_five_channel_upmix_unit.sv]
// tb_stereo_to_five_channel_upmix_unit: stimulus, idling and verdict for the
// upmix unit; prediction and comparison live in upmix5_checker
// depends on upmix5_pkg, upmix5_checker and stereo_to_five_channel_upmix_unit
module tb_stereo_to_five_channel_upmix_unit;

   localparam int STALL_LIMIT = 5000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   upmix5_pkg::sample_type req_left_in;
   upmix5_pkg::sample_type req_right_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   upmix5_pkg::sample_type rsp_front_left;
   upmix5_pkg::sample_type rsp_front_right;
   upmix5_pkg::sample_type rsp_surround_left;
   upmix5_pkg::sample_type rsp_surround_right;
   upmix5_pkg::sample_type rsp_center;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_output_mode;
   int                     errors;
   int                     pending;
   logic                   send_gaps;
   int                     idle_cycles;

   stereo_to_five_channel_upmix_unit uut (.*);

   upmix5_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_word(upmix5_pkg::sample_type l, upmix5_pkg::sample_type r);
      req_left_in <= l;
      req_right_in <= r;
      req_valid <= 1'b1;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      if (send_gaps && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_mode(logic [1:0] m);
      csr_output_mode <= m;
      csr_valid <= 1'b1;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic upmix5_pkg::sample_type random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return upmix5_pkg::sample_type'($urandom);
         6: return upmix5_pkg::S_MAX;
         7: return upmix5_pkg::S_MIN;
         default: return upmix5_pkg::sample_type'(int'($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   // receiver: random stall, one long hold-off, a stretch with no stall, then random stall again
   initial begin
      int cyc;
      cyc = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == 3000) begin
            rsp_ready <= 1'b0;
            repeat (500) @(posedge clock);
            cyc += 500;
         end else if (cyc > 9000 && cyc < 20000)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 99) >= 15);
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      logic [1:0] modes [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_in = '0;
      req_right_in = '0;
      csr_valid = 1'b0;
      csr_output_mode = upmix5_pkg::MODE_ALL;
      send_gaps = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_mode(upmix5_pkg::MODE_ALL);
      send_word('0, '0);
      send_word(upmix5_pkg::S_MAX, upmix5_pkg::S_MAX);
      send_word(upmix5_pkg::S_MIN, upmix5_pkg::S_MIN);
      send_word(upmix5_pkg::S_MAX, upmix5_pkg::S_MIN);
      send_word(upmix5_pkg::S_MIN, upmix5_pkg::S_MAX);
      // alternating full scale drives the high-pass paths into clipping
      for (int i = 0; i < 8; i++) begin
         send_word(i[0] ? upmix5_pkg::S_MIN : upmix5_pkg::S_MAX,
                   i[0] ? upmix5_pkg::S_MAX : upmix5_pkg::S_MIN);
      end
      send_word(upmix5_pkg::sample_type'(1), upmix5_pkg::sample_type'(-1));
      send_word(upmix5_pkg::sample_type'(-1), upmix5_pkg::sample_type'(1));
      send_word(upmix5_pkg::sample_type'(24'h555555), upmix5_pkg::sample_type'(24'haaaaaa));
      send_word(upmix5_pkg::sample_type'(24'haaaaaa), upmix5_pkg::sample_type'(24'h555555));
      for (int i = 0; i < 4; i++) send_word('0, '0);
      req_valid <= 1'b0;
      drain();

      modes = '{upmix5_pkg::MODE_NO_CENTER, upmix5_pkg::MODE_MUTE_ALL,
                upmix5_pkg::MODE_RESERVED, upmix5_pkg::MODE_ALL};
      foreach (modes[p]) begin
         write_mode(modes[p]);
         send_gaps = (p != 1);
         for (int i = 0; i < 320; i++) send_word(random_sample(), random_sample());
         req_valid <= 1'b0;
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
